// ----- rtl/ils_pkg.sv -----
// shared command, status and cell control definitions for the indexed list store
`default_nettype none

package ils_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_GET        = 3'd4,
        CMD_INSERT     = 3'd5,
        CMD_REMOVE     = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REDUCE
    } state_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic write;
        logic shift_up;
        logic shift_down;
        logic rd_en;
    } cell_ctrl_t;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned GROUP    = 16;

endpackage

`default_nettype wire

// ----- rtl/ils_cell.sv -----
// one storage cell of the list: holds an entry and trades it with its neighbours
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned IDX_W      = 8,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic                  clk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [IDX_W-1:0]      pos,
    input  wire logic [IDX_W-1:0]      rd_idx,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [DATA_WIDTH-1:0] below_data,
    input  wire logic [DATA_WIDTH-1:0] above_data,
    output logic      [DATA_WIDTH-1:0] data_out,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write && (MY_IDX == pos))
        begin
            entry_next = data_in;
        end
        else if (ctrl.shift_up && (MY_IDX > pos))
        begin
            entry_next = below_data;
        end
        else if (ctrl.shift_down && (MY_IDX >= pos))
        begin
            entry_next = above_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data_out = entry_reg;
    assign rd_data  = (ctrl.rd_en && (MY_IDX == rd_idx)) ? entry_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/indexed_list_store_unit.sv -----
// top level of the indexed list store: command decode, cell row and read-out tree
`default_nettype none

// Ordered store of up to CAPACITY entries held in a row of cells, one entry per
// cell. Each command transfer returns exactly one result transfer carrying the
// entry read (zero unless a successful get or pop), a status and the count held
// afterwards. Inserts and removes shift the entries at and above the position by
// one place, front pushes and pops the whole row. The result passes through two
// steps: decode and update the cells while the addressed cell's entry is gathered
// into registered groups of 16, then combine the groups into the output register.
// One command is in flight at a time; the next is accepted in the cycle after the
// result has moved into the output register. A result still waiting in the output
// register holds the command in the combine step until it is taken.
// No clearing pass after reset.

module indexed_list_store_unit
    import ils_pkg::*;
#(
    parameter int unsigned CAPACITY   = 256,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // command [2:0], position [11:3], entry_in [DATA_WIDTH+11:12], zero pad
    input  wire logic [((CMD_W + POS_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // entry_out [DATA_WIDTH-1:0], status, entry_count, zero pad
    output logic      [((DATA_WIDTH + STATUS_W + COUNT_W + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int unsigned IDX_W      = $clog2(CAPACITY);
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] group_reg  [NUM_GROUPS];
    logic [DATA_WIDTH-1:0] group_next [NUM_GROUPS];
    logic                  m_tvalid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    status_t               out_status_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic exec_en;
    logic load_out;

    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] cell_pos;
    logic [IDX_W-1:0] rd_idx;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0] reduce_data;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] count_ext;
    logic             full;
    logic             empty;
    logic             in_range;
    logic             ins_pos_ok;
    logic [CNT_W-1:0] count_dec;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        exec_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_en = 1'b1;
            end
            ST_REDUCE:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- command decode ----------------
    assign pos_ext    = CMP_W'(pos_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign full       = (count_reg == CAP_CNT);
    assign empty      = (count_reg == '0);
    assign in_range   = (pos_ext < count_ext);
    assign ins_pos_ok = (pos_ext <= count_ext);
    assign count_dec  = count_reg - CNT_W'(1);

    always_comb
    begin
        ctrl        = '0;
        cell_pos    = pos_ext[IDX_W-1:0];
        rd_idx      = pos_ext[IDX_W-1:0];
        status_next = STAT_OK;
        count_next  = count_reg;
        case (cmd_t'(cmd_reg))
            CMD_PUSH_BACK:
            begin
                cell_pos = count_reg[IDX_W-1:0];
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ctrl.write = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                cell_pos = '0;
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ctrl.write    = 1'b1;
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                rd_idx = count_dec[IDX_W-1:0];
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ctrl.rd_en = 1'b1;
                    count_next = count_dec;
                end
            end
            CMD_POP_FRONT:
            begin
                rd_idx   = '0;
                cell_pos = '0;
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ctrl.rd_en      = 1'b1;
                    ctrl.shift_down = 1'b1;
                    count_next      = count_dec;
                end
            end
            CMD_GET:
            begin
                if (in_range)
                begin
                    ctrl.rd_en = 1'b1;
                end
                else
                begin
                    status_next = empty ? STAT_EMPTY : STAT_BAD_INDEX;
                end
            end
            CMD_INSERT:
            begin
                if (!ins_pos_ok)
                begin
                    status_next = STAT_BAD_INDEX;
                end
                else if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ctrl.write    = 1'b1;
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    ctrl.shift_down = 1'b1;
                    count_next      = count_dec;
                end
                else
                begin
                    status_next = empty ? STAT_EMPTY : STAT_BAD_INDEX;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!exec_en)
        begin
            ctrl = '0;
        end
    end

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] below;
        logic [DATA_WIDTH-1:0] above;

        if (i == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_inner_lo
            assign below = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign above = cell_data[i];
        end
        else
        begin : g_inner_hi
            assign above = cell_data[i+1];
        end

        ils_cell #(
            .INDEX      (i),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (cell_pos),
            .rd_idx     (rd_idx),
            .data_in    (data_reg),
            .below_data (below),
            .above_data (above),
            .data_out   (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // ---------------- read-out tree ----------------
    // only the addressed cell drives a non-zero word, so an or tree selects it
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        always_comb
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CAPACITY)
                begin
                    group_next[g] = group_next[g] | cell_rd[g * GROUP + j];
                end
            end
        end
    end

    always_comb
    begin
        reduce_data = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            reduce_data = reduce_data | group_reg[g];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_en)
            begin
                count_reg <= count_next;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tdata[CMD_W-1:0];
            pos_reg  <= s_tdata[CMD_W +: POS_W];
            data_reg <= s_tdata[CMD_W + POS_W +: DATA_WIDTH];
        end
        if (exec_en)
        begin
            status_reg <= status_next;
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
        if (load_out)
        begin
            out_data_reg   <= reduce_data;
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
        end
    end

    // ---------------- result transfer ----------------
    always_comb
    begin
        m_tdata = '0;
        m_tdata[DATA_WIDTH-1:0]                   = out_data_reg;
        m_tdata[DATA_WIDTH +: STATUS_W]           = out_status_reg;
        m_tdata[DATA_WIDTH + STATUS_W +: COUNT_W] = COUNT_W'(out_count_reg);
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire
